@@ src/pll_divider_select_assert.svh @@
// assertion macros shared by the pll divider select rtl
`ifndef PLL_DIVIDER_SELECT_ASSERT_SVH
`define PLL_DIVIDER_SELECT_ASSERT_SVH

// same-cycle implication, checked out of reset
`define PDS_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked out of reset
`define PDS_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ src/pds_pkg.sv @@
// shared types and constants for the pll divider select block
package pds_pkg;

   localparam int CSR_IDX_W  = 2;
   localparam int REF_CLK_W  = 16;
   localparam int REF_DIV_W  = 10;
   localparam int RATIO_W    = 5;
   localparam int CODE_W     = 3;
   localparam int FB_W       = 30;
   localparam int WORD_W     = 31;
   localparam int CODE_SHIFT = 16;
   localparam int MIN_MULT   = 12;
   localparam int NUM_POST   = 8;
   localparam int SEL_W      = 3;

   localparam logic [CSR_IDX_W-1:0] REG_REF_CLOCK   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_REF_DIVIDER = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_VCO_MIN     = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_VCO_MAX     = 2'd3;

   localparam int REF_CLOCK_RESET   = 2700;
   localparam int REF_DIVIDER_RESET = 12;
   localparam int VCO_MIN_RESET     = 12000;
   localparam int VCO_MAX_RESET     = 35000;
   localparam int VCO_MIN_Q_RESET   = VCO_MIN_RESET / MIN_MULT;

   // post dividers in search order and their hardware codes
   localparam logic [RATIO_W-1:0] POST_RATIO [NUM_POST] =
      '{5'd1, 5'd2, 5'd4, 5'd8, 5'd3, 5'd16, 5'd6, 5'd12};
   localparam logic [CODE_W-1:0] POST_CODE [NUM_POST] =
      '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4, 3'd5, 3'd6, 3'd7};

   typedef struct packed {
      logic advance;
      logic accept;
   } pipe_ctl_type;

   typedef struct packed {
      logic [RATIO_W-1:0] ratio;
      logic [CODE_W-1:0]  code;
      logic               found;
   } post_sel_type;

endpackage

@@ src/pds_csr.sv @@
// configuration registers and the vco_min divide-by-twelve unit
module pds_csr #(
   parameter int FREQ_BITS = 20
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [pds_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [FREQ_BITS-1:0]             csr_wdata,
   output logic [pds_pkg::REF_CLK_W-1:0]    ref_clock,
   output logic [pds_pkg::REF_DIV_W-1:0]    ref_divider,
   output logic [FREQ_BITS-1:0]             vco_min,
   output logic [FREQ_BITS-1:0]             vco_max,
   output logic [FREQ_BITS-1:0]             vco_min_q
);

   localparam int QTR_W = FREQ_BITS - 2;
   localparam int PRD_W = QTR_W + 33;
   localparam logic [32:0] THIRD_RECIP = 33'hAAAAAAAB;

   logic [pds_pkg::REF_CLK_W-1:0] ref_clock_ff;
   logic [pds_pkg::REF_DIV_W-1:0] ref_divider_ff;
   logic [FREQ_BITS-1:0]          vco_min_ff;
   logic [FREQ_BITS-1:0]          vco_max_ff;
   logic [FREQ_BITS-1:0]          vco_min_q_ff, vco_min_q_in;
   logic [PRD_W-1:0]              third_prod;

   // divide by twelve as a quarter, then a third by reciprocal multiply
   always_comb begin
      third_prod   = PRD_W'(csr_wdata[FREQ_BITS-1:2]) * PRD_W'(THIRD_RECIP);
      vco_min_q_in = {2'b00, third_prod[PRD_W-1:33]};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ref_clock_ff   <= pds_pkg::REF_CLK_W'(pds_pkg::REF_CLOCK_RESET);
         ref_divider_ff <= pds_pkg::REF_DIV_W'(pds_pkg::REF_DIVIDER_RESET);
         vco_min_ff     <= FREQ_BITS'(pds_pkg::VCO_MIN_RESET);
         vco_max_ff     <= FREQ_BITS'(pds_pkg::VCO_MAX_RESET);
         vco_min_q_ff   <= FREQ_BITS'(pds_pkg::VCO_MIN_Q_RESET);
      end else if (csr_valid) begin
         unique case (csr_index)
            pds_pkg::REG_REF_CLOCK: begin
               ref_clock_ff <= csr_wdata[pds_pkg::REF_CLK_W-1:0];
            end
            pds_pkg::REG_REF_DIVIDER: begin
               ref_divider_ff <= csr_wdata[pds_pkg::REF_DIV_W-1:0];
            end
            pds_pkg::REG_VCO_MIN: begin
               vco_min_ff   <= csr_wdata;
               vco_min_q_ff <= vco_min_q_in;
            end
            pds_pkg::REG_VCO_MAX: begin
               vco_max_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   assign csr_ready   = 1'b1;
   assign ref_clock   = ref_clock_ff;
   assign ref_divider = ref_divider_ff;
   assign vco_min     = vco_min_ff;
   assign vco_max     = vco_max_ff;
   assign vco_min_q   = vco_min_q_ff;

endmodule

@@ src/pds_front.sv @@
// clamp, post divider search and dividend stages
module pds_front #(
   parameter int FREQ_BITS = 20,
   parameter int DIVD_W    = FREQ_BITS + pds_pkg::REF_DIV_W
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pds_pkg::pipe_ctl_type         ctl,
   input  logic [FREQ_BITS-1:0]          target_clock,
   input  logic [pds_pkg::REF_CLK_W-1:0] ref_clock,
   input  logic [pds_pkg::REF_DIV_W-1:0] ref_divider,
   input  logic [FREQ_BITS-1:0]          vco_min,
   input  logic [FREQ_BITS-1:0]          vco_max,
   input  logic [FREQ_BITS-1:0]          vco_min_q,
   output logic                          out_valid,
   output logic [DIVD_W-1:0]             dividend,
   output logic [FREQ_BITS-1:0]          dot_clock,
   output logic [FREQ_BITS-1:0]          vco_freq,
   output pds_pkg::post_sel_type         post_sel
);

   localparam int PW = FREQ_BITS + pds_pkg::RATIO_W;
   localparam int MW = FREQ_BITS + 4;

   logic [5:0]                    v_ff;
   logic [FREQ_BITS-1:0]          clk1_ff, clk2_ff, clk3_ff, clk4_ff, clk5_ff, clk6_ff;
   logic [FREQ_BITS-1:0]          clk1_in, clk2_in;
   logic [pds_pkg::NUM_POST-1:0]  fit3_ff, fit3_in;
   logic [FREQ_BITS-1:0]          vco4_ff, vco5_ff, vco6_ff, vco4_in;
   pds_pkg::post_sel_type         sel4_ff, sel5_ff, sel6_ff, sel4_in;
   logic [DIVD_W-1:0]             prod5_ff, prod5_in, sum6_ff, sum6_in;
   logic [MW-1:0]                 clk_x12;
   logic [PW-1:0]                 vco_full;
   logic [pds_pkg::SEL_W-1:0]     sel_idx;

   assign clk1_in = (target_clock > vco_max) ? vco_max : target_clock;

   always_comb begin
      clk_x12 = (MW'(clk1_ff) << 3) + (MW'(clk1_ff) << 2);
      clk2_in = (clk_x12 < MW'(vco_min)) ? vco_min_q : clk1_ff;
   end

   always_comb begin
      for (int i = 0; i < pds_pkg::NUM_POST; i++) begin
         fit3_in[i] = (PW'(clk2_ff) * PW'(pds_pkg::POST_RATIO[i]) >= PW'(vco_min)) &&
                      (PW'(clk2_ff) * PW'(pds_pkg::POST_RATIO[i]) <= PW'(vco_max));
      end
   end

   // first fitting entry in search order wins
   always_comb begin
      sel_idx = '0;
      for (int i = pds_pkg::NUM_POST - 1; i >= 0; i--) begin
         if (fit3_ff[i]) begin
            sel_idx = pds_pkg::SEL_W'(i);
         end
      end
      sel4_in.found = |fit3_ff;
      sel4_in.ratio = sel4_in.found ? pds_pkg::POST_RATIO[sel_idx] : '0;
      sel4_in.code  = sel4_in.found ? pds_pkg::POST_CODE[sel_idx] : '0;
      vco_full      = PW'(clk3_ff) * PW'(sel4_in.ratio);
      vco4_in       = vco_full[FREQ_BITS-1:0];
   end

   assign prod5_in = DIVD_W'(ref_divider) * DIVD_W'(vco4_ff);
   assign sum6_in  = prod5_ff + DIVD_W'(ref_clock >> 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (ctl.advance) begin
         v_ff <= {v_ff[4:0], ctl.accept};
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         clk1_ff  <= clk1_in;
         clk2_ff  <= clk2_in;
         clk3_ff  <= clk2_ff;
         fit3_ff  <= fit3_in;
         clk4_ff  <= clk3_ff;
         vco4_ff  <= vco4_in;
         sel4_ff  <= sel4_in;
         clk5_ff  <= clk4_ff;
         vco5_ff  <= vco4_ff;
         sel5_ff  <= sel4_ff;
         prod5_ff <= prod5_in;
         clk6_ff  <= clk5_ff;
         vco6_ff  <= vco5_ff;
         sel6_ff  <= sel5_ff;
         sum6_ff  <= sum6_in;
      end
   end

   assign out_valid = v_ff[5];
   assign dividend  = sum6_ff;
   assign dot_clock = clk6_ff;
   assign vco_freq  = vco6_ff;
   assign post_sel  = sel6_ff;

endmodule

@@ src/pds_div.sv @@
// pipelined restoring divider, one quotient bit per stage
module pds_div #(
   parameter int DIVD_W = 30,
   parameter int DIVS_W = 16,
   parameter int QUO_W  = 30,
   parameter int PAY_W  = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pds_pkg::pipe_ctl_type ctl,
   input  logic                  in_valid,
   input  logic [DIVD_W-1:0]     dividend,
   input  logic [DIVS_W-1:0]     divisor,
   input  logic [PAY_W-1:0]      in_pay,
   output logic                  out_valid,
   output logic [QUO_W-1:0]      quotient,
   output logic [PAY_W-1:0]      out_pay
);

   logic              val_ff [DIVD_W];
   logic [DIVS_W-1:0] rem_ff [DIVD_W];
   logic [DIVD_W-1:0] num_ff [DIVD_W];
   logic [QUO_W-1:0]  quo_ff [DIVD_W];
   logic [PAY_W-1:0]  pay_ff [DIVD_W];
   logic [DIVS_W-1:0] rem_in [DIVD_W];
   logic [DIVD_W-1:0] num_in [DIVD_W];
   logic [QUO_W-1:0]  quo_in [DIVD_W];

   for (genvar k = 0; k < DIVD_W; k++) begin : g_stage
      logic [DIVS_W-1:0] rem_prev;
      logic [DIVD_W-1:0] num_prev;
      logic [QUO_W-1:0]  quo_prev;
      logic [DIVS_W:0]   trial;
      logic              ge;

      if (k == 0) begin : g_first
         assign rem_prev = '0;
         assign num_prev = dividend;
         assign quo_prev = '0;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign num_prev = num_ff[k-1];
         assign quo_prev = quo_ff[k-1];
      end

      always_comb begin
         trial     = {rem_prev, num_prev[DIVD_W-1]};
         ge        = trial >= (DIVS_W+1)'(divisor);
         rem_in[k] = ge ? DIVS_W'(trial - (DIVS_W+1)'(divisor)) : trial[DIVS_W-1:0];
         num_in[k] = num_prev << 1;
         quo_in[k] = {quo_prev[QUO_W-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[k] <= 1'b0;
         end else if (ctl.advance) begin
            val_ff[k] <= (k == 0) ? in_valid : val_ff[(k == 0) ? 0 : k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (ctl.advance) begin
            rem_ff[k] <= rem_in[k];
            num_ff[k] <= num_in[k];
            quo_ff[k] <= quo_in[k];
            pay_ff[k] <= (k == 0) ? in_pay : pay_ff[(k == 0) ? 0 : k-1];
         end
      end
   end

   assign out_valid = val_ff[DIVD_W-1];
   assign quotient  = quo_ff[DIVD_W-1];
   assign out_pay   = pay_ff[DIVD_W-1];

endmodule

@@ src/pll_divider_select.sv @@
// top level of the pll post and feedback divider selection pipeline
//
// req channel: one beat carries a requested dot clock (10 kHz units) in
// req_tdata. rsp channel: one beat per request with the clamped clock, vco
// frequency, post divider and code, feedback divider and divider word in
// rsp_tdata, and the no-fit flag in rsp_tuser. csr channel: writes
// ref_clock (0), ref_divider (1), vco_min (2) and vco_max (3).
// six stages of clamping, post divider search and dividend forming, then
// one stage per dividend bit of the restoring divider for the feedback
// divider.
// one beat per cycle unless the receiver stalls; the divider chain sets the depth.
// a csr write takes effect at its accepting edge, vco_min / 12 included;
// csr_ready stays high.
// reset loads the register defaults and empties the pipeline.
// when the receiver stalls, the whole pipeline holds and req_tready drops;
// nothing is lost or repeated.
module pll_divider_select #(
   parameter int FREQ_BITS = 20
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // target_clock
   input  logic [((FREQ_BITS+7)/8)*8-1:0] req_tdata,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // dot_clock, vco_freq, post_divider, post_code, feedback_divider, divider_word
   output logic [((2*FREQ_BITS+69+7)/8)*8-1:0] rsp_tdata,
   // no_fit
   output logic                           rsp_tuser,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [pds_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [FREQ_BITS-1:0]           csr_wdata
);

   localparam int DIVD_W = FREQ_BITS + pds_pkg::REF_DIV_W;
   localparam int PAY_W  = 2 * FREQ_BITS + pds_pkg::RATIO_W + pds_pkg::CODE_W + 1;
   localparam int RSP_W  = 2 * FREQ_BITS + 69;
   localparam int RSP_TW = ((RSP_W + 7) / 8) * 8;

   logic [pds_pkg::REF_CLK_W-1:0] ref_clock;
   logic [pds_pkg::REF_DIV_W-1:0] ref_divider;
   logic [FREQ_BITS-1:0]          vco_min, vco_max, vco_min_q;
   pds_pkg::pipe_ctl_type         ctl;
   logic                          front_valid;
   logic [DIVD_W-1:0]             dividend;
   logic [FREQ_BITS-1:0]          front_clk, front_vco, out_clk, out_vco;
   pds_pkg::post_sel_type         front_sel, out_sel;
   logic [pds_pkg::FB_W-1:0]      feedback_divider;
   logic [pds_pkg::WORD_W-1:0]    divider_word;

   assign ctl.advance = ~rsp_tvalid | rsp_tready;
   assign req_tready  = ctl.advance;
   assign ctl.accept  = req_tvalid & req_tready;

   pds_csr #(.FREQ_BITS(FREQ_BITS)) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .ref_clock   (ref_clock),
      .ref_divider (ref_divider),
      .vco_min     (vco_min),
      .vco_max     (vco_max),
      .vco_min_q   (vco_min_q)
   );

   pds_front #(.FREQ_BITS(FREQ_BITS), .DIVD_W(DIVD_W)) u_front (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .target_clock (req_tdata[FREQ_BITS-1:0]),
      .ref_clock    (ref_clock),
      .ref_divider  (ref_divider),
      .vco_min      (vco_min),
      .vco_max      (vco_max),
      .vco_min_q    (vco_min_q),
      .out_valid    (front_valid),
      .dividend     (dividend),
      .dot_clock    (front_clk),
      .vco_freq     (front_vco),
      .post_sel     (front_sel)
   );

   pds_div #(
      .DIVD_W (DIVD_W),
      .DIVS_W (pds_pkg::REF_CLK_W),
      .QUO_W  (pds_pkg::FB_W),
      .PAY_W  (PAY_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .in_valid  (front_valid),
      .dividend  (dividend),
      .divisor   (ref_clock),
      .in_pay    ({front_sel, front_vco, front_clk}),
      .out_valid (rsp_tvalid),
      .quotient  (feedback_divider),
      .out_pay   ({out_sel, out_vco, out_clk})
   );

   assign divider_word = pds_pkg::WORD_W'(feedback_divider) |
                         (pds_pkg::WORD_W'(out_sel.code) << pds_pkg::CODE_SHIFT);

   assign rsp_tdata = RSP_TW'({divider_word, feedback_divider, out_sel.code,
                               out_sel.ratio, out_vco, out_clk});
   assign rsp_tuser = ~out_sel.found;

`include "pll_divider_select_assert.svh"

   `PDS_ASSERT_NOW(a_stall_blocks_req, rsp_tvalid && !rsp_tready, !req_tready,
      "request taken while response stalled")
   `PDS_ASSERT_NOW(a_nofit_zero, rsp_tvalid && rsp_tuser,
      out_sel.ratio == '0 && out_sel.code == '0 && out_vco == '0, "no-fit beat carries a divider")
   `PDS_ASSERT_NOW(a_fit_ratio, rsp_tvalid && !rsp_tuser,
      out_sel.ratio == 5'd1 || out_sel.ratio == 5'd2 || out_sel.ratio == 5'd4 ||
      out_sel.ratio == 5'd8 || out_sel.ratio == 5'd3 || out_sel.ratio == 5'd16 ||
      out_sel.ratio == 5'd6 || out_sel.ratio == 5'd12, "fit beat has bad post divider")
   `PDS_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser),
      "stalled response beat changed")

endmodule
